### hw/rtl/ixp_pkg.sv
// ----------------------------------------------------------------------------
// ixp_pkg
// Shared constants, codes and word types of the XOR parity packetizer.
// ----------------------------------------------------------------------------
package ixp_pkg;

  localparam int PAYLOAD_BYTES = 1024;
  localparam int MAX_GROUPS    = 16;

  localparam int PAY_SHIFT   = $clog2(PAYLOAD_BYTES);
  localparam int STRIDE      = PAYLOAD_BYTES + 2;
  localparam int STORE_DEPTH = MAX_GROUPS * STRIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SOFF_W      = $clog2(STRIDE);
  localparam int FILL_W      = $clog2(STRIDE + 1);
  localparam int FLEN_W      = $clog2(PAYLOAD_BYTES + 1);
  localparam int LEN_W       = 26;
  localparam int CNT_W       = LEN_W - PAY_SHIFT + 1;
  localparam int GRP_W       = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int GTOT_W      = $clog2(MAX_GROUPS + 1);
  localparam int ACC_W       = $clog2(MAX_GROUPS * 255 + 1);
  localparam int IDX_W       = 16;
  localparam int OFF_W       = 11;
  localparam int MAX_FRAGS   = 65535;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DROP = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  localparam logic [1:0] K_PLAIN = 2'd0;
  localparam logic [1:0] K_XOR   = 2'd1;
  localparam logic [1:0] K_PAR   = 2'd2;

  localparam logic REQ_DATA = 1'b0;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             is_parity;
    logic [IDX_W-1:0] packet_index;
    logic [OFF_W-1:0] byte_offset;
    logic             packet_last;
    logic             frame_last;
    logic             parity_last;
    logic [IDX_W-1:0] fragment_count;
    logic             fec_active;
    logic [1:0]       status;
  } result_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              clr;
    logic [GRP_W-1:0]  grp;
    logic [SOFF_W-1:0] soff;
    logic [FLEN_W-1:0] flen;
    result_t           res;
  } work_t;

endpackage

### hw/rtl/ixp_queue.sv
// ----------------------------------------------------------------------------
// ixp_queue
// Four-word queue between the front and back ends.
// ----------------------------------------------------------------------------
module ixp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ixp_pkg::work_t wdata,
  output logic          full,
  input  logic          pop,
  output ixp_pkg::work_t rdata,
  output logic          empty
);

  ixp_pkg::work_t buf_q [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;

  assign full  = cnt == 3'd4;
  assign empty = cnt == 3'd0;
  assign rdata = buf_q[rp];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      buf_q[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) begin
        wp <= wp + 2'd1;
      end
      if (pop && !empty) begin
        rp <= rp + 2'd1;
      end
      cnt <= cnt + 3'((push && !full) ? 1 : 0) - 3'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

### hw/rtl/ixp_front.sv
// ----------------------------------------------------------------------------
// ixp_front
// Accepts words, tracks frame/fragment/drain position, sizes the parity
// groups at frame start and queues one tagged work word per input.
// ----------------------------------------------------------------------------
module ixp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       req_type,
  input  logic [7:0]                 data_byte,
  input  logic [ixp_pkg::LEN_W-1:0]  frame_length,
  input  logic                       fec_enable,
  input  logic [7:0]                 fec_group_size,
  input  logic                       q_full,
  output logic                       q_push,
  output ixp_pkg::work_t             q_data
);

  localparam logic [1:0] F_RUN  = 2'd0;
  localparam logic [1:0] F_SRCH = 2'd1;
  localparam logic [1:0] F_EMIT = 2'd2;

  logic [1:0] state;
  logic       in_prog;
  logic       fec_on;
  logic       dropped;
  logic       pend;
  logic [ixp_pkg::LEN_W-1:0]  total;
  logic [ixp_pkg::LEN_W-1:0]  seen;
  logic [ixp_pkg::CNT_W-1:0]  count;
  logic [ixp_pkg::IDX_W-1:0]  fc;
  logic [ixp_pkg::SOFF_W-1:0] off;
  logic [ixp_pkg::GRP_W-1:0]  cg;
  logic [ixp_pkg::GTOT_W-1:0] gtot;
  logic [ixp_pkg::GTOT_W-1:0] dg;
  logic [ixp_pkg::SOFF_W-1:0] doff;
  logic [ixp_pkg::GTOT_W-1:0] srch_k;
  logic [ixp_pkg::ACC_W-1:0]  srch_acc;
  logic [7:0]                 hold_byte;

  logic                       in_prog_next;
  logic                       pend_next;
  logic [ixp_pkg::LEN_W-1:0]  seen_next;
  logic [ixp_pkg::IDX_W-1:0]  fc_next;
  logic [ixp_pkg::SOFF_W-1:0] off_next;
  logic [ixp_pkg::GRP_W-1:0]  cg_next;
  logic [ixp_pkg::GTOT_W-1:0] dg_next;
  logic [ixp_pkg::SOFF_W-1:0] doff_next;

  logic                       accept;
  logic                       start;
  logic                       do_proc;
  logic                       p_req;
  logic [7:0]                 p_byte;
  logic [ixp_pkg::LEN_W-1:0]  len_eff;
  logic [ixp_pkg::CNT_W-1:0]  cnt_new;
  logic [7:0]                 gs1;
  logic                       flast;
  logic [ixp_pkg::LEN_W:0]    rem;
  logic [ixp_pkg::FLEN_W-1:0] flen;
  logic                       plast;
  logic                       dlast;
  logic                       glast;
  ixp_pkg::work_t             w;

  assign full   = (state != F_RUN) || q_full;
  assign accept = push && !full;
  assign start  = accept && (req_type == ixp_pkg::REQ_DATA) && !in_prog;
  assign do_proc = (accept && !start) || (state == F_EMIT && !q_full);
  assign q_push = do_proc;
  assign q_data = w;

  assign gs1     = (fec_group_size == 8'd0) ? 8'd1 : fec_group_size;
  assign len_eff = (frame_length == '0) ? ixp_pkg::LEN_W'(1) : frame_length;
  assign cnt_new = ixp_pkg::CNT_W'(({1'b0, len_eff} + (ixp_pkg::LEN_W + 1)'(
                     ixp_pkg::PAYLOAD_BYTES - 1)) >> ixp_pkg::PAY_SHIFT);

  always_comb begin
    p_req  = (state == F_EMIT) ? ixp_pkg::REQ_DATA : req_type;
    p_byte = (state == F_EMIT) ? hold_byte : data_byte;

    flast = ({1'b0, seen} + 1'b1) >= {1'b0, total};
    rem   = {1'b0, total} - ((ixp_pkg::LEN_W + 1)'(fc) << ixp_pkg::PAY_SHIFT);
    flen  = (rem < (ixp_pkg::LEN_W + 1)'(ixp_pkg::PAYLOAD_BYTES)) ?
            ixp_pkg::FLEN_W'(rem) : ixp_pkg::FLEN_W'(ixp_pkg::PAYLOAD_BYTES);
    plast = (int'(off) + 1) >= int'(flen);
    dlast = int'(doff) == ixp_pkg::STRIDE - 1;
    glast = dlast && ((int'(dg) + 1) >= int'(gtot));

    in_prog_next = in_prog;
    pend_next    = pend;
    seen_next    = seen;
    fc_next      = fc;
    off_next     = off;
    cg_next      = cg;
    dg_next      = dg;
    doff_next    = doff;

    w       = '0;
    w.clr   = state == F_EMIT;
    w.kind  = ixp_pkg::K_PLAIN;
    w.res.out_byte = p_byte;

    if (p_req == ixp_pkg::REQ_DATA) begin
      if (dropped) begin
        w.res.out_byte   = 8'd0;
        w.res.frame_last = flast;
        w.res.status     = ixp_pkg::ST_DROP;
      end else begin
        w.kind = fec_on ? ixp_pkg::K_XOR : ixp_pkg::K_PLAIN;
        w.grp  = cg;
        w.soff = off;
        w.flen = flen;
        w.res.packet_index   = fc;
        w.res.byte_offset    = ixp_pkg::OFF_W'(off);
        w.res.packet_last    = plast;
        w.res.frame_last     = flast;
        w.res.fragment_count = ixp_pkg::IDX_W'(count);
        w.res.fec_active     = fec_on;
        if (plast) begin
          off_next = '0;
          fc_next  = fc + 1'b1;
          if (gtot != '0) begin
            cg_next = ((int'(cg) + 1) >= int'(gtot)) ? '0 : cg + 1'b1;
          end
        end else begin
          off_next = off + 1'b1;
        end
      end
      seen_next = seen + 1'b1;
      if (flast) begin
        in_prog_next = 1'b0;
        if (fec_on && !dropped) begin
          pend_next = 1'b1;
          dg_next   = '0;
          doff_next = '0;
        end
      end
    end else if (!pend) begin
      w.res.out_byte = 8'd0;
      w.res.status   = ixp_pkg::ST_NONE;
    end else begin
      w.kind = ixp_pkg::K_PAR;
      w.grp  = ixp_pkg::GRP_W'(dg);
      w.soff = doff;
      w.res.out_byte       = 8'd0;
      w.res.is_parity      = 1'b1;
      w.res.packet_index   = ixp_pkg::IDX_W'(dg);
      w.res.byte_offset    = ixp_pkg::OFF_W'(doff);
      w.res.packet_last    = dlast;
      w.res.parity_last    = glast;
      w.res.fragment_count = ixp_pkg::IDX_W'(count);
      w.res.fec_active     = 1'b1;
      if (dlast) begin
        doff_next = '0;
        dg_next   = dg + 1'b1;
      end else begin
        doff_next = doff + 1'b1;
      end
      if (glast) begin
        pend_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hold_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_RUN;
      in_prog  <= 1'b0;
      fec_on   <= 1'b0;
      dropped  <= 1'b0;
      pend     <= 1'b0;
      total    <= '0;
      seen     <= '0;
      count    <= '0;
      fc       <= '0;
      off      <= '0;
      cg       <= '0;
      gtot     <= '0;
      dg       <= '0;
      doff     <= '0;
      srch_k   <= '0;
      srch_acc <= '0;
    end else begin
      case (state)
        F_RUN: begin
          if (start) begin
            in_prog <= 1'b1;
            total   <= len_eff;
            count   <= cnt_new;
            seen    <= '0;
            fc      <= '0;
            off     <= '0;
            cg      <= '0;
            pend    <= 1'b0;
            dg      <= '0;
            doff    <= '0;
            dropped <= int'(cnt_new) > ixp_pkg::MAX_FRAGS;
            if (int'(cnt_new) > ixp_pkg::MAX_FRAGS || !fec_enable) begin
              fec_on <= 1'b0;
              gtot   <= '0;
              state  <= F_EMIT;
            end else begin
              srch_k   <= ixp_pkg::GTOT_W'(1);
              srch_acc <= ixp_pkg::ACC_W'(gs1);
              state    <= F_SRCH;
            end
          end
        end
        F_SRCH: begin
          // smallest k with k*group_size >= fragments, give up past the limit
          if (int'(srch_acc) >= int'(count)) begin
            fec_on <= 1'b1;
            gtot   <= srch_k;
            state  <= F_EMIT;
          end else if (int'(srch_k) == ixp_pkg::MAX_GROUPS) begin
            fec_on <= 1'b0;
            gtot   <= '0;
            state  <= F_EMIT;
          end else begin
            srch_k   <= srch_k + 1'b1;
            srch_acc <= srch_acc + ixp_pkg::ACC_W'(gs1);
          end
        end
        F_EMIT: begin
          if (!q_full) begin
            state <= F_RUN;
          end
        end
        default: begin
          state <= F_RUN;
        end
      endcase
      if (do_proc) begin
        in_prog <= in_prog_next;
        pend    <= pend_next;
        seen    <= seen_next;
        fc      <= fc_next;
        off     <= off_next;
        cg      <= cg_next;
        dg      <= dg_next;
        doff    <= doff_next;
      end
    end
  end

endmodule

### hw/rtl/ixp_back.sv
// ----------------------------------------------------------------------------
// ixp_back
// Parity store read-modify-write engine and two-word result buffer.
// ----------------------------------------------------------------------------
module ixp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  ixp_pkg::work_t q_data,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output ixp_pkg::result_t out_res
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RD   = 2'd1;
  localparam logic [1:0] B_WR   = 2'd2;

  localparam logic [1:0] OP_HI   = 2'd0;
  localparam logic [1:0] OP_LO   = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;
  localparam logic [1:0] OP_PAR  = 2'd3;

  logic [7:0] mem [ixp_pkg::STORE_DEPTH];
  logic [ixp_pkg::FILL_W-1:0] fill [ixp_pkg::MAX_GROUPS];

  logic [1:0]       state;
  logic [1:0]       op;
  ixp_pkg::work_t   cur;
  logic [7:0]       rd_byte;
  logic             rd_vld;

  ixp_pkg::result_t ob [2];
  logic             ob_wp;
  logic             ob_rp;
  logic [1:0]       ob_cnt;
  logic             ob_full;
  logic             ob_push;
  ixp_pkg::result_t ob_wdata;

  logic [ixp_pkg::SOFF_W-1:0] op_off;
  logic [7:0]                 op_val;
  logic [ixp_pkg::ADDR_W-1:0] addr;
  logic [7:0]                 old_byte;
  logic                       mem_we;

  assign ob_full   = ob_cnt == 2'd2;
  assign out_empty = ob_cnt == 2'd0;
  assign out_res   = ob[ob_rp];
  assign q_pop     = (state == B_IDLE) && !q_empty && !ob_full;
  assign old_byte  = rd_vld ? rd_byte : 8'd0;
  assign mem_we    = (state == B_WR) && (op != OP_PAR);

  always_comb begin
    case (op)
      OP_HI:   op_off = '0;
      OP_LO:   op_off = ixp_pkg::SOFF_W'(1);
      OP_DATA: op_off = cur.soff + ixp_pkg::SOFF_W'(2);
      default: op_off = cur.soff;
    endcase
    case (op)
      OP_HI:   op_val = 8'(cur.flen >> 8);
      OP_LO:   op_val = cur.flen[7:0];
      default: op_val = cur.res.out_byte;
    endcase
    addr = ixp_pkg::ADDR_W'(int'(cur.grp) * ixp_pkg::STRIDE + int'(op_off));

    ob_push  = 1'b0;
    ob_wdata = cur.res;
    if (q_pop && q_data.kind == ixp_pkg::K_PLAIN) begin
      ob_push  = 1'b1;
      ob_wdata = q_data.res;
    end else if (state == B_WR && op == OP_PAR) begin
      ob_push           = 1'b1;
      ob_wdata.out_byte = old_byte;
    end else if (state == B_WR && op == OP_DATA) begin
      ob_push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= old_byte ^ op_val;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_RD) begin
      rd_byte <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (state == B_RD) begin
      // entries past the group's fill mark hold last frame's data: read as zero
      rd_vld <= int'(op_off) < int'(fill[cur.grp]);
    end
    if (ob_push) begin
      ob[ob_wp] <= ob_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      op     <= OP_HI;
      ob_wp  <= 1'b0;
      ob_rp  <= 1'b0;
      ob_cnt <= '0;
      for (int i = 0; i < ixp_pkg::MAX_GROUPS; i++) begin
        fill[i] <= '0;
      end
    end else begin
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            if (q_data.clr) begin
              for (int i = 0; i < ixp_pkg::MAX_GROUPS; i++) begin
                fill[i] <= '0;
              end
            end
            if (q_data.kind == ixp_pkg::K_PAR) begin
              op    <= OP_PAR;
              state <= B_RD;
            end else if (q_data.kind == ixp_pkg::K_XOR) begin
              op    <= (q_data.soff == '0) ? OP_HI : OP_DATA;
              state <= B_RD;
            end
          end
        end
        B_RD: begin
          state <= B_WR;
        end
        B_WR: begin
          if (mem_we && int'(op_off) >= int'(fill[cur.grp])) begin
            fill[cur.grp] <= ixp_pkg::FILL_W'(int'(op_off) + 1);
          end
          if (op == OP_PAR || op == OP_DATA) begin
            state <= B_IDLE;
          end else begin
            op    <= op + 2'd1;
            state <= B_RD;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
      if (ob_push) begin
        ob_wp <= ~ob_wp;
      end
      if (out_pop && !out_empty) begin
        ob_rp <= ~ob_rp;
      end
      ob_cnt <= ob_cnt + 2'(ob_push ? 1 : 0) - 2'((out_pop && !out_empty) ? 1 : 0);
    end
  end

endmodule

### hw/rtl/interleaved_xor_parity_packetizer_top.sv
// ----------------------------------------------------------------------------
// interleaved_xor_parity_packetizer_top
// Frame byte packetizer with interleaved XOR parity groups.
// ----------------------------------------------------------------------------
// Input queue side: push a word while full is low. req_type 0 carries a frame
// byte (frame_length is sampled on the first byte of each frame), req_type 1
// pulls the next parity byte. Every word yields exactly one result word on
// the output queue side (empty/pop), in order.
// Without parity, data words and requests with nothing pending pass at one
// word per cycle, except at frame start, while the output is not stalled.
// With parity on, the single-port parity store fetches the word, then
// reads and writes each byte; the first byte of a fragment also updates the
// two length bytes first, and a parity byte is read and passed out
// unwritten. The engine takes no new word until it is done with the last.
// Frame start: with parity enabled, the group count is found by a
// sequential search over up to MAX_GROUPS group counts while full is high;
// the held first byte is then issued. A 4-word queue decouples the front
// from the store engine and a 2-word output buffer keeps the engine
// working while the receiver stalls; when both fill, full goes high. Reset
// empties everything and clears all frame state; the parity store needs
// no clearing pass. Configuration (APB, byte addresses 0 and 4) is to be
// written only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module interleaved_xor_parity_packetizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  input  logic [25:0] frame_length,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        is_parity,
  output logic [15:0] packet_index,
  output logic [10:0] byte_offset,
  output logic        packet_last,
  output logic        frame_last,
  output logic        parity_last,
  output logic [15:0] fragment_count,
  output logic        fec_active,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       fec_enable;
  logic [7:0] fec_group_size;

  logic             q_full;
  logic             q_push;
  ixp_pkg::work_t   q_wdata;
  logic             q_empty;
  logic             q_pop;
  ixp_pkg::work_t   q_rdata;
  ixp_pkg::result_t res;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {24'd0, fec_group_size} : {31'd0, fec_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      fec_enable     <= 1'b0;
      fec_group_size <= 8'd8;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        fec_group_size <= pwdata[7:0];
      end else begin
        fec_enable <= pwdata[0];
      end
    end
  end

  ixp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .req_type       (req_type),
    .data_byte      (data_byte),
    .frame_length   (frame_length),
    .fec_enable     (fec_enable),
    .fec_group_size (fec_group_size),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  ixp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  ixp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (empty),
    .out_pop   (pop),
    .out_res   (res)
  );

  assign out_byte       = res.out_byte;
  assign is_parity      = res.is_parity;
  assign packet_index   = res.packet_index;
  assign byte_offset    = res.byte_offset;
  assign packet_last    = res.packet_last;
  assign frame_last     = res.frame_last;
  assign parity_last    = res.parity_last;
  assign fragment_count = res.fragment_count;
  assign fec_active     = res.fec_active;
  assign status         = res.status;

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_parity_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_parity) |-> (status == ixp_pkg::ST_OK && fec_active))
    else $error("parity word with bad status");

  a_parity_no_frame_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_parity) |-> !frame_last)
    else $error("parity word marked as frame end");

  a_parity_last_marks: assert property (@(posedge clk) disable iff (rst)
    (!empty && parity_last) |-> (is_parity && packet_last))
    else $error("parity end outside a parity packet end");

endmodule
